>>> hdl/ilir_pkg.sv
// indexed list engine: shared constants, codes, word types and
// controller/datapath command and status structs; no dependencies
package ilir_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W      = 7;
   localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   // function codes
   localparam logic [2:0] FUNC_APPEND      = 3'd0;
   localparam logic [2:0] FUNC_INSERT      = 3'd1;
   localparam logic [2:0] FUNC_REMOVE_LAST = 3'd2;
   localparam logic [2:0] FUNC_REMOVE_AT   = 3'd3;
   localparam logic [2:0] FUNC_READ        = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] item_value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [6:0]         count;
   } rsp_type;

   typedef enum logic [1:0] {
      WSEL_APPEND,
      WSEL_SHIFT,
      WSEL_PLACE
   } wsel_type;

   typedef enum logic [2:0] {
      RSEL_POS,
      RSEL_CNT_M1,
      RSEL_IDX_M2,
      RSEL_POS_P1,
      RSEL_IDX_P2
   } rsel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_FROM_COUNT,
      IDX_FROM_POS,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_STATUS,
      RSP_DATA
   } rsp_sel_type;

   typedef struct packed {
      logic        load;
      logic        mem_we;
      wsel_type    wsel;
      rsel_type    rsel;
      idx_op_type  idx_op;
      cnt_op_type  cnt_op;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic [1:0] code;
      logic       up_needed;
      logic       down_single;
      logic       up_last;
      logic       down_last;
   } stat_type;

endpackage

>>> hdl/ilir_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ilir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ilir_dp.sv
// indexed list datapath: request registers, fill count, move index,
// entry ram, status checks and result register; uses ilir_pkg, ilir_ram
module ilir_dp import ilir_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_word,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_word
);

   logic [2:0]            func_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CMP_W-1:0]      pos_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_word_ff, rsp_word_in;

   logic [CMP_W-1:0]      count_x, idx_x, rd_x, wr_x;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic                  empty, full;
   logic [1:0]            code;

   assign count_x = CMP_W'(count_ff);
   assign idx_x   = CMP_W'(idx_ff);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == COUNT_W'(CAPACITY));

   // request checks, in the order of precedence per function
   always_comb begin
      code = STAT_OK;
      case (func_ff) inside
         FUNC_APPEND: begin
            if (full) code = STAT_FULL;
         end
         FUNC_INSERT: begin
            if (pos_ff > count_x) code = STAT_RANGE;
            else if (full)        code = STAT_FULL;
         end
         FUNC_REMOVE_LAST: begin
            if (empty) code = STAT_EMPTY;
         end
         FUNC_REMOVE_AT, FUNC_READ: begin
            if (empty)                  code = STAT_EMPTY;
            else if (pos_ff >= count_x) code = STAT_RANGE;
         end
         default: code = STAT_RANGE;
      endcase
   end

   always_comb begin
      stat.func        = func_ff;
      stat.code        = code;
      stat.up_needed   = (pos_ff < count_x);
      stat.down_single = ((pos_ff + CMP_W'(1)) == count_x);
      stat.up_last     = (idx_x == (pos_ff + CMP_W'(1)));
      stat.down_last   = ((idx_x + CMP_W'(2)) == count_x);
   end

   // ram addressing
   always_comb begin
      case (cmd.rsel)
         RSEL_POS:    rd_x = pos_ff;
         RSEL_CNT_M1: rd_x = count_x - CMP_W'(1);
         RSEL_IDX_M2: rd_x = idx_x - CMP_W'(2);
         RSEL_POS_P1: rd_x = pos_ff + CMP_W'(1);
         RSEL_IDX_P2: rd_x = idx_x + CMP_W'(2);
         default:     rd_x = pos_ff;
      endcase
   end

   always_comb begin
      case (cmd.wsel)
         WSEL_APPEND: begin
            wr_x    = count_x;
            wr_data = val_ff;
         end
         WSEL_SHIFT: begin
            wr_x    = idx_x;
            wr_data = rd_data;
         end
         default: begin
            wr_x    = pos_ff;
            wr_data = val_ff;
         end
      endcase
   end

   ilir_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_we),
      .wr_addr (wr_x[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_x[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.idx_op)
         IDX_FROM_COUNT: idx_in = count_ff;
         IDX_FROM_POS:   idx_in = pos_ff[COUNT_W-1:0];
         IDX_DEC:        idx_in = idx_ff - COUNT_W'(1);
         IDX_INC:        idx_in = idx_ff + COUNT_W'(1);
         default:        idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + COUNT_W'(1);
         CNT_DEC: count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // result word, count reflects the request's own update
   always_comb begin
      rsp_valid_in           = (cmd.rsp_sel != RSP_NONE);
      rsp_word_in.count      = POS_W'(count_in);
      if (cmd.rsp_sel == RSP_DATA) begin
         rsp_word_in.status     = STAT_OK;
         rsp_word_in.read_value = 32'($signed(rd_data));
      end else begin
         rsp_word_in.status     = code;
         rsp_word_in.read_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_word.func;
         val_ff  <= DATA_WIDTH'(req_word.item_value);
         pos_ff  <= CMP_W'(req_word.position);
      end
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> hdl/ilir_ctrl.sv
// indexed list controller: one-hot sequencer for checks, entry moves
// and result issue; uses ilir_pkg
module ilir_ctrl import ilir_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CHECK      = 6'b000010,
      ST_READ       = 6'b000100,
      ST_SHIFT_UP   = 6'b001000,
      ST_PLACE      = 6'b010000,
      ST_SHIFT_DOWN = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.mem_we  = 1'b0;
      cmd.wsel    = WSEL_APPEND;
      cmd.rsel    = RSEL_POS;
      cmd.idx_op  = IDX_HOLD;
      cmd.cnt_op  = CNT_HOLD;
      cmd.rsp_sel = RSP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.code != STAT_OK) begin
               cmd.rsp_sel = RSP_STATUS;
               state_in    = ST_IDLE;
            end else begin
               case (stat.func)
                  FUNC_APPEND: begin
                     cmd.mem_we  = 1'b1;
                     cmd.wsel    = WSEL_APPEND;
                     cmd.cnt_op  = CNT_INC;
                     cmd.rsp_sel = RSP_STATUS;
                     state_in    = ST_IDLE;
                  end
                  FUNC_INSERT: begin
                     if (stat.up_needed) begin
                        cmd.idx_op = IDX_FROM_COUNT;
                        cmd.rsel   = RSEL_CNT_M1;
                        state_in   = ST_SHIFT_UP;
                     end else begin
                        cmd.mem_we  = 1'b1;
                        cmd.wsel    = WSEL_PLACE;
                        cmd.cnt_op  = CNT_INC;
                        cmd.rsp_sel = RSP_STATUS;
                        state_in    = ST_IDLE;
                     end
                  end
                  FUNC_REMOVE_LAST: begin
                     cmd.cnt_op  = CNT_DEC;
                     cmd.rsp_sel = RSP_STATUS;
                     state_in    = ST_IDLE;
                  end
                  FUNC_REMOVE_AT: begin
                     if (stat.down_single) begin
                        cmd.cnt_op  = CNT_DEC;
                        cmd.rsp_sel = RSP_STATUS;
                        state_in    = ST_IDLE;
                     end else begin
                        cmd.idx_op = IDX_FROM_POS;
                        cmd.rsel   = RSEL_POS_P1;
                        state_in   = ST_SHIFT_DOWN;
                     end
                  end
                  FUNC_READ: begin
                     cmd.rsel = RSEL_POS;
                     state_in = ST_READ;
                  end
                  default: begin
                     cmd.rsp_sel = RSP_STATUS;
                     state_in    = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_sel = RSP_DATA;
            state_in    = ST_IDLE;
         end
         ST_SHIFT_UP: begin
            // entry below idx was read last cycle, write it one up
            cmd.mem_we = 1'b1;
            cmd.wsel   = WSEL_SHIFT;
            if (stat.up_last) begin
               state_in = ST_PLACE;
            end else begin
               cmd.rsel   = RSEL_IDX_M2;
               cmd.idx_op = IDX_DEC;
            end
         end
         ST_PLACE: begin
            cmd.mem_we  = 1'b1;
            cmd.wsel    = WSEL_PLACE;
            cmd.cnt_op  = CNT_INC;
            cmd.rsp_sel = RSP_STATUS;
            state_in    = ST_IDLE;
         end
         ST_SHIFT_DOWN: begin
            // entry above idx was read last cycle, write it one down
            cmd.mem_we = 1'b1;
            cmd.wsel   = WSEL_SHIFT;
            if (stat.down_last) begin
               cmd.cnt_op  = CNT_DEC;
               cmd.rsp_sel = RSP_STATUS;
               state_in    = ST_IDLE;
            end else begin
               cmd.rsel   = RSEL_IDX_P2;
               cmd.idx_op = IDX_INC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/indexed_list_insert_remove_core.sv
// indexed list engine top level: packed ordered list of signed words
// uses ilir_pkg, ilir_ctrl, ilir_dp (which holds the ilir_ram entry store)
//
// usage
//   request: drive req_word (func, item_value, position) and raise start;
//   the word is taken at a rising edge with start high and busy low
//   result: rsp_word (status, read_value, count) is valid for exactly one
//   cycle while rsp_valid is high; the receiver cannot hold it off
// sequencer states from the accepting edge until the return to idle
//   errors, append, remove-last, insert at the end, remove of the last
//   entry: the check state only
//   read-at: check, then a state for the registered ram read
//   insert-at with m = count - position moves: check, m moves, place
//   remove-at with m = count - position - 1 moves: check, then m moves
//   the entry moves go one per cycle through the single-write,
//   single-read entry ram, pipelined read ahead of write
//   the result strobe shows in the cycle after the last busy cycle
// reset
//   synchronous; clears the fill count, the sequencer and the strobe;
//   entry contents are kept, entries at or above the count are never read
module indexed_list_insert_remove_core import ilir_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   ilir_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   ilir_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

>>> tb/sv/tb_top.sv
// self-checking bench for indexed_list_insert_remove_core: a shadow list
// predicts every result word; random grow/shrink/mixed/noise phases drive it
// depends on ilir_pkg and the core rtl only
module tb_top;
   import ilir_pkg::*;

   // function codes the core does not implement
   localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] FUNC_LAST_CODE    = 3'd7;

   localparam int RANDOM_WORDS = 700;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 80;
   localparam int MAX_REPORTS  = 40;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_type;

   // shadow of the list contents; predicts one result word per request word
   class list_shadow_type;
      logic [DATA_WIDTH-1:0] cells [CAPACITY];
      int                    fill;
      rsp_type               pending_rsps [$];
      int                    fails;

      function new();
         fill  = 0;
         fails = 0;
      endfunction

      function int outstanding();
         return pending_rsps.size();
      endfunction

      task report_mismatch(string what);
         fails++;
         if (fails <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function void note_request(req_type w);
         rsp_type               e;
         int                    p;
         logic [DATA_WIDTH-1:0] v;
         e.status     = STAT_OK;
         e.read_value = '0;
         p            = int'(w.position);
         v            = DATA_WIDTH'(w.item_value);
         case (w.func)
            FUNC_APPEND: begin
               if (fill >= CAPACITY) e.status = STAT_FULL;
               else begin
                  cells[fill] = v;
                  fill++;
               end
            end
            FUNC_INSERT: begin
               // range check wins over the full check
               if (p > fill) e.status = STAT_RANGE;
               else if (fill >= CAPACITY) e.status = STAT_FULL;
               else begin
                  for (int i = fill; i > p; i--) cells[i] = cells[i-1];
                  cells[p] = v;
                  fill++;
               end
            end
            FUNC_REMOVE_LAST: begin
               if (fill == 0) e.status = STAT_EMPTY;
               else fill--;
            end
            FUNC_REMOVE_AT: begin
               if (fill == 0) e.status = STAT_EMPTY;
               else if (p >= fill) e.status = STAT_RANGE;
               else begin
                  for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            FUNC_READ: begin
               if (fill == 0) e.status = STAT_EMPTY;
               else if (p >= fill) e.status = STAT_RANGE;
               else e.read_value = 32'(signed'(cells[p]));
            end
            default: e.status = STAT_RANGE;
         endcase
         e.count = 7'(fill);
         pending_rsps.push_back(e);
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (pending_rsps.size() == 0) begin
            report_mismatch($sformatf("result word with no request waiting: %p", got));
            return;
         end
         e = pending_rsps.pop_front();
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.read_value !== e.read_value)
            report_mismatch($sformatf("read_value %h, want %h", got.read_value,
                                      e.read_value));
         if (got.count !== e.count)
            report_mismatch($sformatf("count %0d, want %0d", got.count, e.count));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   list_shadow_type shadow;
   int              stall_cycles = 0;

   indexed_list_insert_remove_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor and stall watchdog; samples pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid) shadow.check_response(rsp_word);
      if (reset || (start && !busy) || rsp_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_type word_of(logic [2:0] f, logic [31:0] v, logic [6:0] p);
      req_type w;
      w.func       = f;
      w.item_value = v;
      w.position   = p;
      return w;
   endfunction

   // present a word and hold it until the core takes it
   task automatic put_word(req_type w);
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      shadow.note_request(w);
   endtask

   task automatic rest(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold the sender off until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // mostly back to back or short gaps, a few long ones
   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(99, 0);
      if (burst || r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // index for insert: 0..fill, now and then past the end
   function automatic logic [6:0] insert_pos(int fill);
      if ($urandom_range(9, 0) == 0) return 7'($urandom_range(127, fill + 1));
      return 7'($urandom_range(fill, 0));
   endfunction

   // index for remove-at and read-at: 0..fill-1, now and then past the end
   function automatic logic [6:0] entry_pos(int fill);
      if (fill == 0 || $urandom_range(9, 0) == 0) return 7'($urandom_range(127, fill));
      return 7'($urandom_range(fill - 1, 0));
   endfunction

   function automatic req_type pick_word(phase_type kind, int fill);
      int         r;
      logic [2:0] f;
      logic [6:0] p;
      r = $urandom_range(99, 0);
      p = 7'($urandom_range(127, 0));
      case (kind)
         PH_GROW: begin
            if (r < 45) f = FUNC_APPEND;
            else if (r < 85) f = FUNC_INSERT;
            else if (r < 92) f = FUNC_READ;
            else if (r < 96) f = FUNC_REMOVE_AT;
            else f = FUNC_REMOVE_LAST;
         end
         PH_SHRINK: begin
            if (r < 40) f = FUNC_REMOVE_LAST;
            else if (r < 80) f = FUNC_REMOVE_AT;
            else if (r < 92) f = FUNC_READ;
            else f = FUNC_APPEND;
         end
         PH_MIXED: begin
            if (r < 20) f = FUNC_APPEND;
            else if (r < 40) f = FUNC_INSERT;
            else if (r < 55) f = FUNC_REMOVE_LAST;
            else if (r < 75) f = FUNC_REMOVE_AT;
            else f = FUNC_READ;
         end
         default: f = 3'($urandom_range(FUNC_LAST_CODE, 0));
      endcase
      if (kind != PH_NOISE) begin
         if (f == FUNC_INSERT) p = insert_pos(fill);
         else if (f == FUNC_REMOVE_AT || f == FUNC_READ) p = entry_pos(fill);
      end
      return word_of(f, pick_value(), p);
   endfunction

   initial begin
      req_type   directed [$];
      phase_type kind;
      int        sent;
      int        phase_left;
      bit        burst;

      shadow = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list cases, then a short build-up and tear-down by index
      directed.push_back(word_of(FUNC_READ,        32'h0,         7'd0));
      directed.push_back(word_of(FUNC_REMOVE_LAST, 32'h0,         7'd0));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd0));
      directed.push_back(word_of(FUNC_INSERT,      32'h1234_5678, 7'd1));
      directed.push_back(word_of(FUNC_INSERT,      32'h8000_0000, 7'd0));
      directed.push_back(word_of(FUNC_APPEND,      32'h7fff_ffff, 7'd0));
      directed.push_back(word_of(FUNC_APPEND,      32'hffff_ffff, 7'd127));
      directed.push_back(word_of(FUNC_INSERT,      32'h0,         7'd3));
      directed.push_back(word_of(FUNC_INSERT,      32'h5a5a_5a5a, 7'd0));
      directed.push_back(word_of(FUNC_INSERT,      32'ha5a5_a5a5, 7'd2));
      directed.push_back(word_of(FUNC_READ,        32'h0,         7'd0));
      directed.push_back(word_of(FUNC_READ,        32'h0,         7'd5));
      directed.push_back(word_of(FUNC_READ,        32'h0,         7'd6));
      directed.push_back(word_of(FUNC_READ,        32'hffff_ffff, 7'd127));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd6));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd64));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd2));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd0));
      directed.push_back(word_of(FUNC_REMOVE_AT,   32'h0,         7'd3));
      directed.push_back(word_of(FUNC_INSERT,      32'h1,         7'd127));
      directed.push_back(word_of(FUNC_FIRST_UNUSED, 32'h1,        7'd0));
      directed.push_back(word_of(FUNC_FIRST_UNUSED + 3'd1, 32'h1, 7'd0));
      directed.push_back(word_of(FUNC_LAST_CODE,   32'h1,         7'd1));
      directed.push_back(word_of(FUNC_REMOVE_LAST, 32'h0,         7'd0));
      directed.push_back(word_of(FUNC_READ,        32'h0,         7'd1));

      foreach (directed[i]) begin
         put_word(directed[i]);
         rest(pick_gap(1'b0));
      end
      drain();

      // random phases: grow toward full, shrink toward empty, mix, noise
      sent       = 0;
      phase_left = 0;
      kind       = PH_GROW;
      burst      = 1'b0;
      while (sent < RANDOM_WORDS) begin
         if (phase_left == 0) begin
            case ($urandom_range(9, 0)) inside
               0, 1, 2: kind = PH_GROW;
               3, 4, 5: kind = PH_SHRINK;
               6, 7, 8: kind = PH_MIXED;
               default: kind = PH_NOISE;
            endcase
            phase_left = $urandom_range(90, 20);
            burst      = ($urandom_range(3, 0) == 0);
         end
         put_word(pick_word(kind, shadow.fill));
         sent++;
         phase_left--;
         rest(pick_gap(burst));
         if (sent % 150 == 0) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.outstanding() != 0)
         shadow.report_mismatch($sformatf("%0d results never came", shadow.outstanding()));

      if (shadow.fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
